### rtl/core/palette_builder_table_core_assert.svh
// Assertion helpers for the palette builder table core.
`ifndef PALETTE_BUILDER_TABLE_CORE_ASSERT_SVH
`define PALETTE_BUILDER_TABLE_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define PBT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("palette builder table: assertion failed");

// next-cycle implication, masked during reset
`define PBT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("palette builder table: assertion failed");

`endif

### rtl/core/pbt_pkg.sv
`default_nettype none

package pbt_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int MAX_EXTRACT_DEF = 64;

   localparam int CSR_W    = 10;
   localparam int CHAN_W   = 8;
   localparam int COLOR_W  = 24;
   localparam int ADD_W    = 24;
   localparam int CNT_W    = 32;
   localparam int RTYPE_W  = 2;
   localparam int RCNT_W   = 7;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 8;
   localparam int DIST_W   = 10;

   // request codes
   localparam logic [RTYPE_W-1:0] REQ_ADD     = 2'd0;
   localparam logic [RTYPE_W-1:0] REQ_CLEAR   = 2'd1;
   localparam logic [RTYPE_W-1:0] REQ_EXTRACT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_MERGED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXTRACTED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_ADD_SCAN,
      S_ADD_WRITE,
      S_CLEAR,
      S_CLEAR_DONE,
      S_EXT_SCAN,
      S_EXT_EMIT
   } state_type;

   // table access strobes
   typedef struct packed {
      logic rd_en;
      logic wr_color;
      logic wr_count;
   } tbl_ctl_type;

endpackage

`default_nettype wire

### rtl/core/pbt_if.sv
`default_nettype none

interface pbt_req_if;
   logic                          valid;
   logic                          ready;
   logic [pbt_pkg::RTYPE_W-1:0]   req_type;
   logic [pbt_pkg::CHAN_W-1:0]    red;
   logic [pbt_pkg::CHAN_W-1:0]    green;
   logic [pbt_pkg::CHAN_W-1:0]    blue;
   logic [pbt_pkg::ADD_W-1:0]     add_count;
   logic [pbt_pkg::RCNT_W-1:0]    result_count;

   modport source (
      output valid, req_type, red, green, blue, add_count, result_count,
      input  ready
   );
   modport sink (
      input  valid, req_type, red, green, blue, add_count, result_count,
      output ready
   );
endinterface

interface pbt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pbt_pkg::STATUS_W-1:0]  status;
   logic [pbt_pkg::IDX_W-1:0]     entry_index;
   logic [pbt_pkg::CHAN_W-1:0]    out_red;
   logic [pbt_pkg::CHAN_W-1:0]    out_green;
   logic [pbt_pkg::CHAN_W-1:0]    out_blue;
   logic [pbt_pkg::CNT_W-1:0]     entry_count;
   logic                          last;

   modport source (
      output valid, status, entry_index, out_red, out_green, out_blue, entry_count, last,
      input  ready
   );
   modport sink (
      input  valid, status, entry_index, out_red, out_green, out_blue, entry_count, last,
      output ready
   );
endinterface

`default_nettype wire

### rtl/core/pbt_table.sv
`default_nettype none

module pbt_table #(
   parameter int TABLE_DEPTH = pbt_pkg::TABLE_DEPTH_DEF,
   parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
   input  wire logic                         clock,
   input  wire pbt_pkg::tbl_ctl_type         ctl,
   input  wire logic [ADDR_W-1:0]            rd_addr,
   input  wire logic [ADDR_W-1:0]            wr_addr,
   input  wire logic [pbt_pkg::COLOR_W-1:0]  wr_color,
   input  wire logic [pbt_pkg::CNT_W-1:0]    wr_count,
   output logic      [pbt_pkg::COLOR_W-1:0]  rd_color,
   output logic      [pbt_pkg::CNT_W-1:0]    rd_count
);

   logic [pbt_pkg::COLOR_W-1:0] color_mem [TABLE_DEPTH];
   logic [pbt_pkg::CNT_W-1:0]   count_mem [TABLE_DEPTH];

   logic [pbt_pkg::COLOR_W-1:0] rd_color_ff;
   logic [pbt_pkg::CNT_W-1:0]   rd_count_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_color) begin
         color_mem[wr_addr] <= wr_color;
      end
      if (ctl.wr_count) begin
         count_mem[wr_addr] <= wr_count;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_color_ff <= color_mem[rd_addr];
         rd_count_ff <= count_mem[rd_addr];
      end
   end

   assign rd_color = rd_color_ff;
   assign rd_count = rd_count_ff;

endmodule

`default_nettype wire

### rtl/core/palette_builder_table_core.sv
// Palette builder table: collects colors with use counts and returns the most used ones.
// req_bus (valid/ready) carries one request word: add a color, clear all counts, or
// extract the top colors. rsp_bus (valid/ready) returns result words; the final word
// of each request has last set. csr_wr_en/csr_wr_data write the match threshold and
// may only be used while the block is idle.
// Add and extract walk the color/count memories one entry per cycle through a single
// synchronous read port; clear walks the count memory in the same order, writing zeros.
// Add returns one result word after its scan; clear returns one word after its sweep.
// Extract rescans the whole table for each returned color; once the table has no
// candidate left, the remaining words are emitted without a further scan.
// A new request is taken once the previous one has been fully processed.
// After reset the block sweeps the table to blacken all colors and zero all counts;
// req_bus.ready stays low during that sweep.
// The result word sits in an output register; when the receiver stalls, the block
// finishes its current scan and then holds until the register is taken.
`default_nettype none

module palette_builder_table_core #(
   parameter int TABLE_DEPTH = pbt_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_EXTRACT = pbt_pkg::MAX_EXTRACT_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   pbt_req_if.sink                        req_bus,
   pbt_rsp_if.source                      rsp_bus,
   input  wire logic                      csr_wr_en,
   input  wire logic [pbt_pkg::CSR_W-1:0] csr_wr_data
);

`include "palette_builder_table_core_assert.svh"

   localparam int                 AddrW    = $clog2(TABLE_DEPTH);
   localparam logic [AddrW-1:0]   LastAddr = AddrW'(TABLE_DEPTH - 1);
   localparam logic [pbt_pkg::RCNT_W-1:0] MaxExt = pbt_pkg::RCNT_W'(MAX_EXTRACT);

   pbt_pkg::state_type state_ff, state_in;

   logic [AddrW-1:0]              addr_ff, addr_in;
   logic                          issue_ff, issue_in;
   logic                          s1_vld_ff, s1_vld_in;
   logic [AddrW-1:0]              s1_idx_ff, s1_idx_in;
   logic [pbt_pkg::CSR_W-1:0]     thr_ff, thr_in;

   logic [pbt_pkg::CHAN_W-1:0]    op_red_ff, op_red_in;
   logic [pbt_pkg::CHAN_W-1:0]    op_green_ff, op_green_in;
   logic [pbt_pkg::CHAN_W-1:0]    op_blue_ff, op_blue_in;
   logic [pbt_pkg::ADD_W-1:0]     op_add_ff, op_add_in;
   logic [pbt_pkg::RCNT_W-1:0]    ext_left_ff, ext_left_in;

   logic                          hit_ff, hit_in;
   logic [AddrW-1:0]              hit_idx_ff, hit_idx_in;
   logic [pbt_pkg::CNT_W-1:0]     hit_cnt_ff, hit_cnt_in;
   logic                          free_ff, free_in;
   logic [AddrW-1:0]              free_idx_ff, free_idx_in;

   logic                          best_vld_ff, best_vld_in;
   logic [AddrW-1:0]              best_idx_ff, best_idx_in;
   logic [pbt_pkg::CNT_W-1:0]     best_cnt_ff, best_cnt_in;
   logic [pbt_pkg::COLOR_W-1:0]   best_color_ff, best_color_in;
   logic                          prev_vld_ff, prev_vld_in;
   logic [AddrW-1:0]              prev_idx_ff, prev_idx_in;
   logic [pbt_pkg::CNT_W-1:0]     prev_cnt_ff, prev_cnt_in;

   logic                          rsp_vld_ff, rsp_vld_in;
   logic [pbt_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [pbt_pkg::IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [pbt_pkg::COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic [pbt_pkg::CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_load;

   pbt_pkg::tbl_ctl_type          tbl_ctl;
   logic [AddrW-1:0]              mem_wr_addr;
   logic [pbt_pkg::COLOR_W-1:0]   mem_wr_color;
   logic [pbt_pkg::CNT_W-1:0]     mem_wr_count;
   logic [pbt_pkg::COLOR_W-1:0]   rd_color;
   logic [pbt_pkg::CNT_W-1:0]     rd_count;

   logic                          req_fire;
   logic                          slot_free;
   logic                          scan_done;
   logic [pbt_pkg::CHAN_W-1:0]    d_red, d_green, d_blue;
   logic [pbt_pkg::DIST_W-1:0]    l1_dist;
   logic                          add_match;
   logic [pbt_pkg::CNT_W:0]       sum_wide;
   logic [pbt_pkg::CNT_W-1:0]     sat_cnt;
   logic                          ext_cand;
   logic [AddrW+7:0]              hit_idx_x, free_idx_x, best_idx_x;

   pbt_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (AddrW)
   ) u_table (
      .clock    (clock),
      .ctl      (tbl_ctl),
      .rd_addr  (addr_ff),
      .wr_addr  (mem_wr_addr),
      .wr_color (mem_wr_color),
      .wr_count (mem_wr_count),
      .rd_color (rd_color),
      .rd_count (rd_count)
   );

   assign req_bus.ready = (state_ff == pbt_pkg::S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_vld_ff || rsp_bus.ready;
   assign scan_done     = s1_vld_ff && (s1_idx_ff == LastAddr);

   // L1 distance of the entry on the read port to the pending color
   assign d_red   = (rd_color[23:16] > op_red_ff) ? rd_color[23:16] - op_red_ff
                                                  : op_red_ff - rd_color[23:16];
   assign d_green = (rd_color[15:8] > op_green_ff) ? rd_color[15:8] - op_green_ff
                                                   : op_green_ff - rd_color[15:8];
   assign d_blue  = (rd_color[7:0] > op_blue_ff) ? rd_color[7:0] - op_blue_ff
                                                 : op_blue_ff - rd_color[7:0];
   assign l1_dist   = {2'b00, d_red} + {2'b00, d_green} + {2'b00, d_blue};
   assign add_match = (l1_dist <= thr_ff);

   assign sum_wide = {1'b0, hit_cnt_ff} + {9'd0, op_add_ff};
   assign sat_cnt  = sum_wide[pbt_pkg::CNT_W] ? '1 : sum_wide[pbt_pkg::CNT_W-1:0];

   // next candidate ranks strictly below the previously extracted entry
   assign ext_cand = (rd_count != '0) &&
                     (!prev_vld_ff || (rd_count < prev_cnt_ff) ||
                      ((rd_count == prev_cnt_ff) && (s1_idx_ff > prev_idx_ff)));

   assign hit_idx_x  = {8'd0, hit_idx_ff};
   assign free_idx_x = {8'd0, free_idx_ff};
   assign best_idx_x = {8'd0, best_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pbt_pkg::S_INIT;
         addr_ff     <= '0;
         issue_ff    <= 1'b0;
         s1_vld_ff   <= 1'b0;
         thr_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         best_vld_ff <= 1'b0;
         prev_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         issue_ff    <= issue_in;
         s1_vld_ff   <= s1_vld_in;
         thr_ff      <= thr_in;
         rsp_vld_ff  <= rsp_vld_in;
         hit_ff      <= hit_in;
         free_ff     <= free_in;
         best_vld_ff <= best_vld_in;
         prev_vld_ff <= prev_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff     <= s1_idx_in;
      op_red_ff     <= op_red_in;
      op_green_ff   <= op_green_in;
      op_blue_ff    <= op_blue_in;
      op_add_ff     <= op_add_in;
      ext_left_ff   <= ext_left_in;
      hit_idx_ff    <= hit_idx_in;
      hit_cnt_ff    <= hit_cnt_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_cnt_ff   <= best_cnt_in;
      best_color_ff <= best_color_in;
      prev_idx_ff   <= prev_idx_in;
      prev_cnt_ff   <= prev_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      s1_vld_in     = 1'b0;
      s1_idx_in     = s1_idx_ff;
      thr_in        = csr_wr_en ? csr_wr_data : thr_ff;
      op_red_in     = op_red_ff;
      op_green_in   = op_green_ff;
      op_blue_in    = op_blue_ff;
      op_add_in     = op_add_ff;
      ext_left_in   = ext_left_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_cnt_in    = hit_cnt_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_cnt_in   = best_cnt_ff;
      best_color_in = best_color_ff;
      prev_vld_in   = prev_vld_ff;
      prev_idx_in   = prev_idx_ff;
      prev_cnt_in   = prev_cnt_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_load      = 1'b0;
      tbl_ctl       = '0;
      mem_wr_addr   = addr_ff;
      mem_wr_color  = '0;
      mem_wr_count  = '0;

      // read issue for a running scan; data returns in the next cycle
      if (issue_ff) begin
         tbl_ctl.rd_en = 1'b1;
         s1_vld_in     = 1'b1;
         s1_idx_in     = addr_ff;
         addr_in       = addr_ff + 1'b1;
         if (addr_ff == LastAddr) begin
            issue_in = 1'b0;
         end
      end

      case (state_ff)
         pbt_pkg::S_INIT: begin
            tbl_ctl.wr_color = 1'b1;
            tbl_ctl.wr_count = 1'b1;
            addr_in          = addr_ff + 1'b1;
            if (addr_ff == LastAddr) begin
               addr_in  = '0;
               state_in = pbt_pkg::S_IDLE;
            end
         end

         pbt_pkg::S_IDLE: begin
            if (req_fire) begin
               op_red_in   = req_bus.red;
               op_green_in = req_bus.green;
               op_blue_in  = req_bus.blue;
               op_add_in   = req_bus.add_count;
               addr_in     = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               best_vld_in = 1'b0;
               case (req_bus.req_type)
                  pbt_pkg::REQ_ADD: begin
                     issue_in = 1'b1;
                     state_in = pbt_pkg::S_ADD_SCAN;
                  end
                  pbt_pkg::REQ_CLEAR: begin
                     state_in = pbt_pkg::S_CLEAR;
                  end
                  pbt_pkg::REQ_EXTRACT: begin
                     if (req_bus.result_count == '0) begin
                        ext_left_in = pbt_pkg::RCNT_W'(1);
                     end else if (req_bus.result_count > MaxExt) begin
                        ext_left_in = MaxExt;
                     end else begin
                        ext_left_in = req_bus.result_count;
                     end
                     prev_vld_in = 1'b0;
                     issue_in    = 1'b1;
                     state_in    = pbt_pkg::S_EXT_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         pbt_pkg::S_ADD_SCAN: begin
            if (s1_vld_ff) begin
               if (add_match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = s1_idx_ff;
                  hit_cnt_in = rd_count;
               end
               if ((rd_count == '0) && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = s1_idx_ff;
               end
            end
            if (scan_done) begin
               state_in = pbt_pkg::S_ADD_WRITE;
            end
         end

         pbt_pkg::S_ADD_WRITE: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_color_in = '0;
               rsp_last_in  = 1'b1;
               if (hit_ff) begin
                  tbl_ctl.wr_count = 1'b1;
                  mem_wr_addr      = hit_idx_ff;
                  mem_wr_count     = sat_cnt;
                  rsp_status_in    = pbt_pkg::ST_MERGED;
                  rsp_index_in     = hit_idx_x[7:0];
                  rsp_count_in     = sat_cnt;
               end else if (free_ff) begin
                  tbl_ctl.wr_color = 1'b1;
                  tbl_ctl.wr_count = 1'b1;
                  mem_wr_addr      = free_idx_ff;
                  mem_wr_color     = {op_red_ff, op_green_ff, op_blue_ff};
                  mem_wr_count     = {8'd0, op_add_ff};
                  rsp_status_in    = pbt_pkg::ST_NEW;
                  rsp_index_in     = free_idx_x[7:0];
                  rsp_count_in     = {8'd0, op_add_ff};
               end else begin
                  rsp_status_in = pbt_pkg::ST_FULL;
                  rsp_index_in  = '0;
                  rsp_count_in  = '0;
               end
               state_in = pbt_pkg::S_IDLE;
            end
         end

         pbt_pkg::S_CLEAR: begin
            tbl_ctl.wr_count = 1'b1;
            addr_in          = addr_ff + 1'b1;
            if (addr_ff == LastAddr) begin
               addr_in  = '0;
               state_in = pbt_pkg::S_CLEAR_DONE;
            end
         end

         pbt_pkg::S_CLEAR_DONE: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = pbt_pkg::ST_CLEARED;
               rsp_index_in  = '0;
               rsp_color_in  = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = pbt_pkg::S_IDLE;
            end
         end

         pbt_pkg::S_EXT_SCAN: begin
            // strict compare keeps the lowest index among equal counts
            if (s1_vld_ff && ext_cand && (!best_vld_ff || (rd_count > best_cnt_ff))) begin
               best_vld_in   = 1'b1;
               best_idx_in   = s1_idx_ff;
               best_cnt_in   = rd_count;
               best_color_in = rd_color;
            end
            if (scan_done) begin
               state_in = pbt_pkg::S_EXT_EMIT;
            end
         end

         pbt_pkg::S_EXT_EMIT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = (ext_left_ff == pbt_pkg::RCNT_W'(1));
               ext_left_in = ext_left_ff - 1'b1;
               if (best_vld_ff) begin
                  rsp_status_in = pbt_pkg::ST_EXTRACTED;
                  rsp_index_in  = best_idx_x[7:0];
                  rsp_color_in  = best_color_ff;
                  rsp_count_in  = best_cnt_ff;
                  prev_vld_in   = 1'b1;
                  prev_idx_in   = best_idx_ff;
                  prev_cnt_in   = best_cnt_ff;
               end else begin
                  rsp_status_in = pbt_pkg::ST_NONE;
                  rsp_index_in  = '0;
                  rsp_color_in  = '0;
                  rsp_count_in  = '0;
               end
               if (ext_left_ff == pbt_pkg::RCNT_W'(1)) begin
                  state_in = pbt_pkg::S_IDLE;
               end else if (best_vld_ff) begin
                  // rescan for the next entry; with no candidate left, stay and emit none
                  addr_in     = '0;
                  issue_in    = 1'b1;
                  best_vld_in = 1'b0;
                  state_in    = pbt_pkg::S_EXT_SCAN;
               end
            end
         end

         default: begin
            state_in = pbt_pkg::S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.entry_index = rsp_index_ff;
   assign rsp_bus.out_red     = rsp_color_ff[23:16];
   assign rsp_bus.out_green   = rsp_color_ff[15:8];
   assign rsp_bus.out_blue    = rsp_color_ff[7:0];
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.last        = rsp_last_ff;

   `PBT_ASSERT_NEXT(a_add_busy, clock, reset, (req_fire && (req_bus.req_type == pbt_pkg::REQ_ADD)), !req_bus.ready)
   `PBT_ASSERT_IMPL(a_load_into_free_slot, clock, reset, rsp_load, (!rsp_vld_ff || rsp_bus.ready))
   `PBT_ASSERT_IMPL(a_no_read_on_write, clock, reset, (tbl_ctl.wr_color || tbl_ctl.wr_count), !tbl_ctl.rd_en)
   `PBT_ASSERT_IMPL(a_single_word_last, clock, reset, (rsp_load && ((state_ff == pbt_pkg::S_ADD_WRITE) || (state_ff == pbt_pkg::S_CLEAR_DONE))), rsp_last_in)

endmodule

`default_nettype wire

### bench/testbench.sv
`default_nettype none

module testbench;
   import pbt_pkg::*;

   localparam int DEPTH         = TABLE_DEPTH_DEF;
   localparam int EXTRACT_MAX   = MAX_EXTRACT_DEF;
   localparam int SETTLE_CYCLES = DEPTH + 16;

   localparam logic [RTYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [CSR_W-1:0]   DIST_MAX   = 10'd765;
   localparam logic [CSR_W-1:0]   CSR_TOP    = '1;
   localparam logic [ADD_W-1:0]   ADD_MAX    = '1;

   typedef struct packed {
      logic [RTYPE_W-1:0] kind;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [ADD_W-1:0]   amount;
      logic [RCNT_W-1:0]  want;
   } table_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [CNT_W-1:0]    count;
      logic                last;
   } table_result_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   pbt_req_if req_bus();
   pbt_rsp_if rsp_bus();

   palette_builder_table_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the palette table and threshold
   logic [COLOR_W-1:0] shadow_color [DEPTH];
   logic [CNT_W-1:0]   shadow_count [DEPTH];
   logic [CSR_W-1:0]   shadow_threshold;

   table_request_type palette_requests[$];
   table_result_type  palette_replies[$];
   int requests_queued;
   int requests_taken;
   int error_count;
   int send_gap, send_calm, take_hold, take_calm;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(64'd2_000_000_000);
      $display("Regression FAIL");
      $finish;
   end

   task automatic flag_error(string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic string show_word(table_result_type w);
      return $sformatf("st=%0d idx=%0d rgb=%0d/%0d/%0d cnt=%0d last=%0d",
                       w.status, w.index, w.red, w.green, w.blue, w.count, w.last);
   endfunction

   function automatic int channel_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // short runs of back-to-back words, otherwise mostly short gaps, few long ones
   function automatic int draw_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(39) == 0) begin
         calm = $urandom_range(80, 20);
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(4, 1);
      return $urandom_range(70, 10);
   endfunction

   function automatic void expect_word(logic [STATUS_W-1:0] st, int idx,
                                       logic [COLOR_W-1:0] color, logic [CNT_W-1:0] cnt,
                                       logic last);
      table_result_type w;
      w.status = st;
      w.index  = IDX_W'(idx);
      {w.red, w.green, w.blue} = color;
      w.count  = cnt;
      w.last   = last;
      palette_replies.push_back(w);
   endfunction

   function automatic void apply_to_palette(table_request_type rq);
      int hit, best, gap_sum, n;
      logic [CNT_W:0]     sum;
      logic [CNT_W-1:0]   peak;
      logic [COLOR_W-1:0] c;
      bit                 taken [DEPTH];
      hit = -1;
      case (rq.kind)
         REQ_ADD: begin
            for (int i = 0; i < DEPTH && hit < 0; i++) begin
               c = shadow_color[i];
               gap_sum = channel_gap(c[2*CHAN_W +: CHAN_W], rq.red)
                       + channel_gap(c[CHAN_W +: CHAN_W], rq.green)
                       + channel_gap(c[0 +: CHAN_W], rq.blue);
               if (gap_sum <= int'(shadow_threshold)) hit = i;
            end
            if (hit >= 0) begin
               sum = {1'b0, shadow_count[hit]} + {9'd0, rq.amount};
               shadow_count[hit] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
               expect_word(ST_MERGED, hit, '0, shadow_count[hit], 1'b1);
            end else begin
               for (int i = 0; i < DEPTH && hit < 0; i++)
                  if (shadow_count[i] == '0) hit = i;
               if (hit >= 0) begin
                  shadow_color[hit] = {rq.red, rq.green, rq.blue};
                  shadow_count[hit] = CNT_W'(rq.amount);
                  expect_word(ST_NEW, hit, '0, shadow_count[hit], 1'b1);
               end else
                  expect_word(ST_FULL, 0, '0, '0, 1'b1);
            end
         end
         REQ_CLEAR: begin
            foreach (shadow_count[i]) shadow_count[i] = '0;
            expect_word(ST_CLEARED, 0, '0, '0, 1'b1);
         end
         REQ_EXTRACT: begin
            n = int'(rq.want);
            if (n == 0) n = 1;
            if (n > EXTRACT_MAX) n = EXTRACT_MAX;
            foreach (taken[i]) taken[i] = 1'b0;
            for (int k = 0; k < n; k++) begin
               peak = '0;
               best = -1;
               // strict compare keeps the lowest index on ties
               for (int i = 0; i < DEPTH; i++)
                  if (!taken[i] && shadow_count[i] > peak) begin
                     peak = shadow_count[i];
                     best = i;
                  end
               if (best >= 0) begin
                  taken[best] = 1'b1;
                  expect_word(ST_EXTRACTED, best, shadow_color[best], peak, k == n - 1);
               end else
                  expect_word(ST_NONE, 0, '0, '0, k == n - 1);
            end
         end
         default: ;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      table_request_type rq;
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.req_type     <= REQ_ADD;
         req_bus.red          <= '0;
         req_bus.green        <= '0;
         req_bus.blue         <= '0;
         req_bus.add_count    <= '0;
         req_bus.result_count <= '0;
         send_gap = 0;
         send_calm = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_to_palette({req_bus.req_type, req_bus.red, req_bus.green, req_bus.blue,
                              req_bus.add_count, req_bus.result_count});
            requests_taken++;
            send_gap = draw_gap(send_calm);
         end else if (!req_bus.valid && send_gap > 0)
            send_gap--;
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (send_gap == 0 && palette_requests.size() > 0) begin
               rq = palette_requests.pop_front();
               req_bus.req_type     <= rq.kind;
               req_bus.red          <= rq.red;
               req_bus.green        <= rq.green;
               req_bus.blue         <= rq.blue;
               req_bus.add_count    <= rq.amount;
               req_bus.result_count <= rq.want;
               req_bus.valid        <= 1'b1;
            end else
               req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      table_result_type seen, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_hold = 0;
         take_calm = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.status, rsp_bus.entry_index, rsp_bus.out_red, rsp_bus.out_green,
                    rsp_bus.out_blue, rsp_bus.entry_count, rsp_bus.last};
            if (palette_replies.size() == 0)
               flag_error({"unexpected word ", show_word(seen)});
            else begin
               want = palette_replies.pop_front();
               if (seen !== want)
                  flag_error({"got ", show_word(seen), " want ", show_word(want)});
            end
            take_hold = draw_gap(take_calm);
         end else if (take_hold > 0)
            take_hold--;
         rsp_bus.ready <= (take_hold == 0);
      end
   end

   task automatic queue_request(logic [RTYPE_W-1:0] kind, logic [CHAN_W-1:0] r,
                                logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
                                logic [ADD_W-1:0] amount, logic [RCNT_W-1:0] want);
      table_request_type rq;
      rq.kind   = kind;
      rq.red    = r;
      rq.green  = g;
      rq.blue   = b;
      rq.amount = amount;
      rq.want   = want;
      palette_requests.push_back(rq);
      requests_queued++;
   endtask

   task automatic set_threshold(logic [CSR_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_threshold = v;
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (requests_taken != requests_queued || palette_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CHAN_W-1:0] near_anchor();
      return CHAN_W'($urandom_range(3) * 80 + $urandom_range(9));
   endfunction

   function automatic logic [CHAN_W-1:0] rand_channel();
      return CHAN_W'($urandom_range(255));
   endfunction

   function automatic logic [RCNT_W-1:0] rand_want();
      return RCNT_W'($urandom_range(127));
   endfunction

   initial begin
      int roll;
      logic [CSR_W-1:0]   thresholds [3];
      logic [RCNT_W-1:0]  want;
      logic [ADD_W-1:0]   amount;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      foreach (shadow_color[i]) shadow_color[i] = '0;
      foreach (shadow_count[i]) shadow_count[i] = '0;
      shadow_threshold = '0;
      requests_queued = 0;
      requests_taken = 0;
      error_count = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // table sweep after reset keeps ready low
      do @(negedge clock); while (req_bus.ready !== 1'b1);

      // directed: exact matching
      set_threshold('0);
      queue_request(REQ_ADD, 8'd0, 8'd0, 8'd0, 24'd5, '0);      // black entry with zero count
      queue_request(REQ_ADD, 8'd255, 8'd255, 8'd255, ADD_MAX, '0);
      queue_request(REQ_ADD, 8'd255, 8'd255, 8'd255, 24'd0, '0);
      queue_request(REQ_ADD, 8'd1, 8'd2, 8'd3, 24'd0, '0);      // zero count keeps slot free
      queue_request(REQ_ADD, 8'd1, 8'd2, 8'd3, 24'd7, '0);
      queue_request(REQ_ADD, 8'd10, 8'd20, 8'd30, 24'd0, '0);
      queue_request(REQ_ADD, 8'd200, 8'd100, 8'd50, 24'd9, '0);
      queue_request(REQ_ADD, 8'd9, 8'd9, 8'd9, 24'd9, '0);      // tie on count
      queue_request(REQ_EXTRACT, '0, '0, '0, '0, 7'd0);
      queue_request(REQ_EXTRACT, '0, '0, '0, '0, 7'd3);
      queue_request(REQ_EXTRACT, '1, '1, '1, '1, 7'd127);
      queue_request(REQ_UNUSED, '1, '1, '1, '1, '1);
      queue_request(REQ_CLEAR, '0, '0, '0, '0, '0);
      queue_request(REQ_EXTRACT, '0, '0, '0, '0, 7'd2);
      queue_request(REQ_ADD, 8'd255, 8'd255, 8'd255, 24'd3, '0);
      wait_quiet();

      set_threshold(DIST_MAX);
      queue_request(REQ_ADD, 8'd0, 8'd0, 8'd0, 24'd1, '0);
      queue_request(REQ_ADD, 8'd255, 8'd0, 8'd255, ADD_MAX, '0);
      queue_request(REQ_ADD, 8'd17, 8'd34, 8'd68, 24'd12, '0);
      queue_request(REQ_EXTRACT, '0, '0, '0, '0, 7'd4);
      wait_quiet();

      set_threshold(CSR_TOP);
      queue_request(REQ_ADD, 8'd128, 8'd128, 8'd128, 24'd2, '0);
      queue_request(REQ_EXTRACT, '0, '0, '0, '0, 7'd1);
      queue_request(REQ_CLEAR, '0, '0, '0, '0, '0);
      wait_quiet();

      // distinct colors until the table fills up
      set_threshold('0);
      queue_request(REQ_CLEAR, '0, '0, '0, '0, '0);
      for (int i = 0; i < 264; i++) begin
         if (i % 130 == 129)
            queue_request(REQ_EXTRACT, '0, '0, '0, '0, RCNT_W'($urandom_range(5, 1)));
         roll = $urandom_range(99);
         if (i % 100 == 50) amount = '0;
         else if (roll < 50) amount = ADD_W'($urandom_range(4, 1));
         else amount = ADD_W'($urandom_range(ADD_MAX, 1));
         queue_request(REQ_ADD, rand_channel(), rand_channel(), rand_channel(),
                       amount, rand_want());
      end
      queue_request(REQ_EXTRACT, '0, '0, '0, '0, 7'd64);
      wait_quiet();

      // everything now lands in entry 0, and its count saturates
      set_threshold(CSR_TOP);
      for (int i = 0; i < 258; i++) begin
         if (i == 128)
            queue_request(REQ_EXTRACT, '0, '0, '0, '0, 7'd3);
         queue_request(REQ_ADD, rand_channel(), rand_channel(), rand_channel(),
                       ADD_MAX, rand_want());
      end
      queue_request(REQ_EXTRACT, '0, '0, '0, '0, 7'd2);
      wait_quiet();

      // mixed traffic around a few anchor colors
      queue_request(REQ_CLEAR, '0, '0, '0, '0, '0);
      wait_quiet();
      thresholds[0] = DIST_MAX;
      thresholds[1] = CSR_W'($urandom_range(120, 1));
      thresholds[2] = CSR_W'($urandom_range(764, 200));
      foreach (thresholds[t]) begin
         set_threshold(thresholds[t]);
         for (int i = 0; i < 8; i++) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
               queue_request(REQ_ADD, near_anchor(), near_anchor(), near_anchor(),
                             ($urandom_range(9) == 0) ? '0 : ADD_W'($urandom()),
                             rand_want());
            end else if (roll < 68) begin
               queue_request(REQ_CLEAR, rand_channel(), rand_channel(),
                             rand_channel(), ADD_W'($urandom()), rand_want());
            end else if (roll < 90) begin
               roll = $urandom_range(9);
               if (roll == 0) want = '0;
               else if (roll == 1) want = RCNT_W'($urandom_range(127, 65));
               else want = RCNT_W'($urandom_range(6, 1));
               queue_request(REQ_EXTRACT, rand_channel(), rand_channel(),
                             rand_channel(), ADD_W'($urandom()), want);
            end else begin
               queue_request(REQ_UNUSED, rand_channel(), rand_channel(),
                             rand_channel(), ADD_W'($urandom()), rand_want());
            end
         end
         wait_quiet();
      end

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
